// File: src/c2dv_pkg.sv
// Shared types, constants and register codes for the 2-D valid convolution block.
`timescale 1ns / 1ps

package c2dv_pkg;

	localparam int KERNEL_DEF    = 3;
	localparam int MAX_WIDTH_DEF = 256;

	localparam int PIX_W       = 16;
	localparam int WGT_W       = 16;
	localparam int PROD_W      = PIX_W + WGT_W;
	localparam int BIAS_W      = 36;
	localparam int VAL_W       = 38;
	localparam int WREG_W      = 64;
	localparam int NUM_WREGS   = 4;
	localparam int WGT_FLAT_W  = NUM_WREGS * WREG_W;
	localparam int WIDTH_REG_W = 9;
	localparam int WIDTH_RESET = 28;
	localparam int MIN_WIDTH   = 4;

	localparam int APB_ADDR_W = 6;
	localparam int APB_DATA_W = 64;

	typedef enum logic [2:0] {
		REG_WEIGHTS_LOW  = 3'd0,
		REG_WEIGHTS_MID  = 3'd1,
		REG_WEIGHTS_HIGH = 3'd2,
		REG_WEIGHTS_TOP  = 3'd3,
		REG_BIAS         = 3'd4,
		REG_INPUT_WIDTH  = 3'd5
	} reg_idx_t;

	// Per-item control that travels with a pixel through the pipeline.
	typedef struct packed {
		logic valid;
		logic produce;
		logic last;
	} ctl_t;

	typedef struct packed {
		logic             valid;
		logic             last;
		logic [VAL_W-1:0] value;
	} res_t;

endpackage

// File: src/c2dv_line_store.sv
// Line store memory: one entry per column holding the older window rows, cleared after reset.
`timescale 1ns / 1ps

module c2dv_line_store
	import c2dv_pkg::*;
#(
	parameter int KERNEL    = KERNEL_DEF,
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]       rd_addr,
	output logic [(KERNEL-1)*PIX_W-1:0]        rd_data,
	input  logic                               wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]       wr_addr,
	input  logic [(KERNEL-1)*PIX_W-1:0]        wr_data,
	output logic                               busy
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int DW = (KERNEL - 1) * PIX_W;

	logic [DW-1:0] line_mem_q [MAX_WIDTH];
	logic          busy_q;
	logic [AW-1:0] clr_addr_q;

	// Sweep every entry to zero once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(MAX_WIDTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			line_mem_q[clr_addr_q] <= '0;
		end else if (wr_en) begin
			line_mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= line_mem_q[rd_addr];
		end
	end

	assign busy = busy_q;

endmodule

// File: src/c2dv_mac.sv
// Window registers, weight products and the summing tree with bias.
`timescale 1ns / 1ps

module c2dv_mac
	import c2dv_pkg::*;
#(
	parameter int KERNEL = KERNEL_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  ctl_t                        ctl_s1,
	input  logic [KERNEL*PIX_W-1:0]     column,
	input  logic [WGT_FLAT_W-1:0]       weights,
	input  logic signed [BIAS_W-1:0]    bias,
	output res_t                        res
);

	logic signed [PIX_W-1:0]  win_q   [KERNEL][KERNEL];
	logic signed [PROD_W-1:0] prod_s3 [KERNEL][KERNEL];
	logic signed [VAL_W-1:0]  row_sum_d  [KERNEL];
	logic signed [VAL_W-1:0]  row_sum_s4 [KERNEL];
	logic signed [VAL_W-1:0]  total_d;
	logic [VAL_W-1:0]         total_s5;
	logic                     v_s2, v_s3, v_s4, v_s5;
	logic                     last_s2, last_s3, last_s4, last_s5;

	// Shift the window left and take the new column on the right.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int ro = 0; ro < KERNEL; ro++) begin
				for (int co = 0; co < KERNEL; co++) begin
					win_q[ro][co] <= '0;
				end
			end
		end else if (adv && ctl_s1.valid) begin
			for (int ro = 0; ro < KERNEL; ro++) begin
				for (int co = 0; co < KERNEL - 1; co++) begin
					win_q[ro][co] <= win_q[ro][co+1];
				end
				win_q[ro][KERNEL-1] <= column[ro*PIX_W +: PIX_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s2 <= ctl_s1.valid && ctl_s1.produce;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2 <= ctl_s1.last;
			last_s3 <= last_s2;
			last_s4 <= last_s3;
			last_s5 <= last_s4;
			for (int ro = 0; ro < KERNEL; ro++) begin
				for (int co = 0; co < KERNEL; co++) begin
					prod_s3[ro][co] <= win_q[ro][co] *
						$signed(weights[WGT_W*(ro*KERNEL+co) +: WGT_W]);
				end
			end
			row_sum_s4 <= row_sum_d;
			total_s5   <= total_d;
		end
	end

	// Row sums; the bias rides on the oldest row.
	always_comb begin
		for (int ro = 0; ro < KERNEL; ro++) begin
			row_sum_d[ro] = (ro == 0) ? VAL_W'(bias) : '0;
			for (int co = 0; co < KERNEL; co++) begin
				row_sum_d[ro] = row_sum_d[ro] + VAL_W'(prod_s3[ro][co]);
			end
		end
	end

	always_comb begin
		total_d = '0;
		for (int ro = 0; ro < KERNEL; ro++) begin
			total_d = total_d + row_sum_s4[ro];
		end
	end

	assign res.valid = v_s5;
	assign res.last  = last_s5;
	assign res.value = total_s5;

endmodule

// File: src/conv2d_valid_single_kernel.sv
// Top level of the streaming 2-D valid convolution with one kernel and a bias.
// A result passes the stage 1 register, MAC stages 2 to 5 and the output register before result_valid rises.
// Throughput: one pixel per cycle while pixel_stall is low, set by the single line store read and write-back per pixel.
// A two-entry output stage (register plus skid) keeps input flowing for one stalled result.
// Reset: registers take their reset values; the line store is then swept clear entry by entry,
// during which pixel_stall stays high (configuration writes still work).
`timescale 1ns / 1ps

module conv2d_valid_single_kernel
	import c2dv_pkg::*;
#(
	parameter int KERNEL    = KERNEL_DEF,
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_W-1:0]    paddr,
	input  logic [APB_DATA_W-1:0]    pwdata,
	output logic [APB_DATA_W-1:0]    prdata,
	output logic                     pready,
	// pixel channel
	input  logic                     pixel_valid,
	output logic                     pixel_stall,
	input  logic signed [PIX_W-1:0]  pixel,
	// result channel
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic signed [VAL_W-1:0]  value,
	output logic                     last
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WB = ((CW > WIDTH_REG_W) ? CW : WIDTH_REG_W) + 1;
	localparam int LW = (KERNEL - 1) * PIX_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [WREG_W-1:0]       weights_q [NUM_WREGS];
	logic signed [BIAS_W-1:0] bias_q;
	logic [WIDTH_REG_W-1:0]  width_q;
	logic                    cfg_wr;
	reg_idx_t                reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WREGS; i++) begin
				weights_q[i] <= '0;
			end
			bias_q  <= '0;
			width_q <= WIDTH_REG_W'(WIDTH_RESET);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_WEIGHTS_LOW:  weights_q[0] <= pwdata;
				REG_WEIGHTS_MID:  weights_q[1] <= pwdata;
				REG_WEIGHTS_HIGH: weights_q[2] <= pwdata;
				REG_WEIGHTS_TOP:  weights_q[3] <= pwdata;
				REG_BIAS:         bias_q  <= pwdata[BIAS_W-1:0];
				REG_INPUT_WIDTH:  width_q <= pwdata[WIDTH_REG_W-1:0];
				default: ;        // unmapped address: drop the write
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WEIGHTS_LOW:  prdata = weights_q[0];
			REG_WEIGHTS_MID:  prdata = weights_q[1];
			REG_WEIGHTS_HIGH: prdata = weights_q[2];
			REG_WEIGHTS_TOP:  prdata = weights_q[3];
			REG_BIAS:         prdata = APB_DATA_W'(unsigned'(bias_q));
			REG_INPUT_WIDTH:  prdata = APB_DATA_W'(width_q);
			default:          prdata = '0;
		endcase
	end

	// Weight 0 sits in the low bits of weights_low, weight 15 at the top of weights_top.
	logic [WGT_FLAT_W-1:0] weights_flat;
	assign weights_flat = {weights_q[3], weights_q[2], weights_q[1], weights_q[0]};

	// Effective width: clamp the register to MIN_WIDTH .. MAX_WIDTH, keep width - 1.
	logic [WB-1:0] width_ext, width_clamp, width_m1_ext;
	logic [CW-1:0] eff_m1;

	always_comb begin
		width_ext = WB'(width_q);
		if (width_ext < WB'(MIN_WIDTH)) begin
			width_clamp = WB'(MIN_WIDTH);
		end else if (width_ext > WB'(MAX_WIDTH)) begin
			width_clamp = WB'(MAX_WIDTH);
		end else begin
			width_clamp = width_ext;
		end
		width_m1_ext = width_clamp - WB'(1);
		eff_m1       = width_m1_ext[CW-1:0];
	end

	// ------------------------------------------------------------------
	// Pipeline control
	// ------------------------------------------------------------------
	// The whole pipeline moves together; it only halts when both output
	// slots are taken. The line store sweep blocks new pixels.
	logic mem_busy;
	logic skid_v_q;
	logic adv;
	logic accept;

	assign adv         = !skid_v_q;
	assign pixel_stall = mem_busy || skid_v_q;
	assign accept      = pixel_valid && !pixel_stall;

	// ------------------------------------------------------------------
	// Stage 0: raster counters and line store read
	// ------------------------------------------------------------------
	logic [CW-1:0] col_q, row_q;
	logic          row_end, frame_end, produce;

	assign row_end   = col_q >= eff_m1;
	assign frame_end = row_end && (row_q >= eff_m1);
	assign produce   = (col_q >= CW'(KERNEL - 1)) && (row_q >= CW'(KERNEL - 1));

	// Counters fall back to zero at the end of a row or frame, even after
	// the width has shrunk under them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: line store data arrives; build the column, write it back
	// ------------------------------------------------------------------
	ctl_t                    ctl_s1;
	logic signed [PIX_W-1:0] pixel_s1;
	logic [CW-1:0]           addr_s1;
	logic [LW-1:0]           rd_data;
	logic [KERNEL*PIX_W-1:0] column;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid   <= accept;
			ctl_s1.produce <= produce;
			ctl_s1.last    <= frame_end;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixel;
			addr_s1  <= col_q;
		end
	end

	// Oldest row in the low slot, the new pixel on top. The write-back drops
	// the oldest row. A column comes back at least MIN_WIDTH pixels later,
	// so the read and the write-back of one entry never overlap.
	assign column = {pixel_s1, rd_data};

	c2dv_line_store #(
		.KERNEL    (KERNEL),
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (adv && ctl_s1.valid),
		.wr_addr (addr_s1),
		.wr_data (column[KERNEL*PIX_W-1:PIX_W]),
		.busy    (mem_busy)
	);

	// ------------------------------------------------------------------
	// Stages 2 to 5: window, products, row sums, total
	// ------------------------------------------------------------------
	res_t res;

	c2dv_mac #(
		.KERNEL (KERNEL)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_s1  (ctl_s1),
		.column  (column),
		.weights (weights_flat),
		.bias    (bias_q),
		.res     (res)
	);

	// ------------------------------------------------------------------
	// Output register with skid slot
	// ------------------------------------------------------------------
	logic             out_v_q;
	logic [VAL_W-1:0] out_value_q, skid_value_q;
	logic             out_last_q, skid_last_q;
	logic             out_free;
	logic             load_from_skid, load_from_pipe, load_skid;

	assign out_free       = !out_v_q || !result_stall;
	assign load_from_skid = skid_v_q && !result_stall;
	assign load_from_pipe = !skid_v_q && res.valid && out_free;
	assign load_skid      = !skid_v_q && res.valid && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (load_from_skid) begin
				skid_v_q <= 1'b0;
			end else if (load_skid) begin
				skid_v_q <= 1'b1;
			end
			if (load_from_skid || load_from_pipe) begin
				out_v_q <= 1'b1;
			end else if (!result_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_from_skid) begin
			out_value_q <= skid_value_q;
			out_last_q  <= skid_last_q;
		end else if (load_from_pipe) begin
			out_value_q <= res.value;
			out_last_q  <= res.last;
		end
		if (load_skid) begin
			skid_value_q <= res.value;
			skid_last_q  <= res.last;
		end
	end

	assign result_valid = out_v_q;
	assign value        = out_value_q;
	assign last         = out_last_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// A result waits in the skid slot only behind a held output.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid slot full while output register empty");

	// No line store read while the clearing sweep runs.
	a_no_read_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mem_busy |-> !accept)
		else $error("pixel accepted during line store clear");

	// A row end always restarts the column counter.
	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && row_end) |=> (col_q == '0))
		else $error("column counter did not wrap at row end");

	// A new result never overwrites a pending one while the skid is full.
	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && result_stall) |=> (skid_v_q && $stable(skid_value_q)))
		else $error("skid slot lost its result");

endmodule

// File: verif/conv2d_valid_single_kernel_tb.sv
// Self-checking testbench for the streaming 2-D valid convolution block.
`timescale 1ns / 1ps

module conv2d_valid_single_kernel_tb;
	import c2dv_pkg::*;

	localparam int K           = KERNEL_DEF;
	localparam int MAXW        = MAX_WIDTH_DEF;
	localparam int ITEM_TARGET = 1250;
	localparam int ITEM_SLACK  = 60;      // allowed overshoot of the last phase
	localparam int DRAIN_WAIT  = 12;      // drain time past the block's pipeline, with margin
	localparam int LONG_HOLD   = 300;     // receiver hold-off for the pressure test
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} conv_result_t;

	// DUT connections; every input starts at a known value
	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    psel         = 1'b0;
	logic                    penable      = 1'b0;
	logic                    pwrite       = 1'b0;
	logic [APB_ADDR_W-1:0]   paddr        = '0;
	logic [APB_DATA_W-1:0]   pwdata       = '0;
	logic [APB_DATA_W-1:0]   prdata;
	logic                    pready;
	logic                    pixel_valid  = 1'b0;
	logic                    pixel_stall;
	logic signed [PIX_W-1:0] pixel        = '0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	logic signed [VAL_W-1:0] value;
	logic                    last;

	// Shadow of the block: configuration, line stores, window and counters
	logic [WREG_W-1:0]      m_wregs [NUM_WREGS];
	logic [BIAS_W-1:0]      m_bias  = '0;
	logic [WIDTH_REG_W-1:0] m_width = WIDTH_REG_W'(WIDTH_RESET);
	logic [PIX_W-1:0]       m_lines [K-1][MAXW];
	logic [PIX_W-1:0]       m_win   [K][K];
	int unsigned            m_col   = 0;
	int unsigned            m_row   = 0;

	conv_result_t expected_results[$];
	conv_result_t chk_want;
	int           err_count     = 0;
	int           pixels_sent   = 0;
	int           cycle_count   = 0;
	bit           tx_gap_on     = 1'b1;
	bit           rx_idle_on    = 1'b1;
	int           hold_requests = 0;
	int           hold_served   = 0;
	int           rx_left       = 0;

	conv2d_valid_single_kernel dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.value       (value),
		.last        (last)
	);

	always #5 clk = ~clk;

	initial begin
		foreach (m_wregs[i]) m_wregs[i] = '0;
		foreach (m_lines[r, c]) m_lines[r][c] = '0;
		foreach (m_win[r, c]) m_win[r][c] = '0;
	end

	// Advance the shadow by one accepted pixel; return 1 when it yields a result.
	function automatic bit conv_predict(input logic [PIX_W-1:0] px, output conv_result_t res);
		int unsigned        w;
		int unsigned        c;
		int unsigned        widx;
		int                 r;
		int                 co;
		logic [PIX_W-1:0]   newcol [K];
		logic [WGT_W-1:0]   wt;
		logic signed [15:0] pv;
		logic signed [15:0] wv;
		longint             acc;
		longint             lp;
		longint             lw;
		bit                 row_end;
		bit                 frame_end;
		bit                 produced;

		// out-of-range widths saturate to the legal span
		w = (m_width < MIN_WIDTH) ? MIN_WIDTH : ((m_width > MAXW) ? MAXW : m_width);
		c = (m_col >= MAXW) ? MAXW - 1 : m_col;

		// pull the column out of the line stores, oldest row first, and push px in
		for (r = 0; r < K - 1; r++) newcol[r] = m_lines[r][c];
		newcol[K-1] = px;
		for (r = 0; r + 1 < K - 1; r++) m_lines[r][c] = m_lines[r+1][c];
		m_lines[K-2][c] = px;

		// shift the window left by one column
		for (r = 0; r < K; r++) begin
			for (co = 0; co + 1 < K; co++) m_win[r][co] = m_win[r][co+1];
			m_win[r][K-1] = newcol[r];
		end

		row_end   = (m_col >= w - 1);
		frame_end = row_end && (m_row >= w - 1);
		produced  = (m_col >= K - 1) && (m_row >= K - 1);

		res.value = '0;
		res.last  = 1'b0;
		if (produced) begin
			acc = {{(64-BIAS_W){m_bias[BIAS_W-1]}}, m_bias};
			for (r = 0; r < K; r++) begin
				for (co = 0; co < K; co++) begin
					widx = r * K + co;
					wt   = m_wregs[widx / 4][16 * (widx % 4) +: WGT_W];
					pv   = m_win[r][co];
					wv   = wt;
					lp   = pv;
					lw   = wv;
					acc  = acc + lp * lw;
				end
			end
			res.value = acc[VAL_W-1:0];
			res.last  = frame_end;
		end

		// counters wrap at the end of a row and of a frame
		if (row_end) begin
			m_col = 0;
			m_row = frame_end ? 0 : m_row + 1;
		end else begin
			m_col = m_col + 1;
		end
		return produced;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Pixels lean toward the extremes so the top and sign bits toggle often
	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
			default: return PIX_W'($urandom());
		endcase
	endfunction

	function automatic logic [WREG_W-1:0] rand_weight_reg();
		logic [WREG_W-1:0] v;
		int                lane;
		for (lane = 0; lane < 4; lane++) begin
			case ($urandom_range(0, 5))
				0: v[16*lane +: 16] = 16'h8000;
				1: v[16*lane +: 16] = 16'h7FFF;
				2: v[16*lane +: 16] = 16'h0000;
				default: v[16*lane +: 16] = 16'($urandom());
			endcase
		end
		return v;
	endfunction

	function automatic logic [APB_DATA_W-1:0] rand_bias();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		case ($urandom_range(0, 7))
			0: return {28'h0, 36'h7_FFFF_FFFF};
			1: return {{28{1'b1}}, 36'h8_0000_0000};
			2: return '0;
			3: return raw;    // junk above bit 35 must be dropped
			default: return {{28{raw[35]}}, raw[35:0]};
		endcase
	endfunction

	// Two-phase register write: setup cycle, then access cycle
	task automatic cfg_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'(8 * int'(idx));
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_BIAS:        m_bias  = data[BIAS_W-1:0];
			REG_INPUT_WIDTH: m_width = data[WIDTH_REG_W-1:0];
			default:         m_wregs[int'(idx)] = data;
		endcase
	endtask

	// Offer one item, hold it until taken, then record what it should yield
	task automatic send_pixel(input logic [PIX_W-1:0] px);
		int           gap;
		conv_result_t res;
		gap = tx_gap_on ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			pixel_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		pixel_valid <= 1'b1;
		pixel       <= px;
		do begin
			@(posedge clk);
		end while (pixel_stall);
		if (conv_predict(px, res)) expected_results.push_back(res);
		pixels_sent++;
	endtask

	// Drop valid, wait out every pending result, then cover the pipeline depth
	// since items that yield nothing may still be in flight
	task automatic wait_idle();
		@(negedge clk);
		pixel_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// One 4x4 frame at the minimum width with extreme weights, bias and pixels.
	// The first window is all -32768 pixels against all -32768 weights plus the top bias.
	task automatic test_directed_extremes();
		logic [PIX_W-1:0] frame [16];
		frame = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF,
			  16'h8000, 16'h8000, 16'h8000, 16'h7FFF,
			  16'h8000, 16'h8000, 16'h8000, 16'h7FFF,
			  16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000};
		cfg_write(REG_WEIGHTS_LOW,  64'h8000_8000_8000_8000);
		cfg_write(REG_WEIGHTS_MID,  64'h8000_8000_8000_8000);
		cfg_write(REG_WEIGHTS_HIGH, 64'h7FFF_0001_FFFF_8000);
		cfg_write(REG_WEIGHTS_TOP,  64'hA5A5_5A5A_FFFF_0000);
		cfg_write(REG_BIAS,         {28'h0, 36'h7_FFFF_FFFF});
		cfg_write(REG_INPUT_WIDTH,  64'd4);
		foreach (frame[i]) send_pixel(frame[i]);
		wait_idle();
	endtask

	// Full width: three rows reach column 255, then narrow the image mid-frame
	// and finish it on stale line store contents
	task automatic test_wide_image();
		cfg_write(REG_WEIGHTS_LOW,  rand_weight_reg());
		cfg_write(REG_WEIGHTS_MID,  rand_weight_reg());
		cfg_write(REG_WEIGHTS_HIGH, rand_weight_reg());
		cfg_write(REG_BIAS,         {{28{1'b1}}, 36'h8_0000_0000});
		cfg_write(REG_INPUT_WIDTH,  64'd256);
		repeat (3 * MAXW) send_pixel(rand_pixel());
		wait_idle();
		cfg_write(REG_INPUT_WIDTH, 64'd8);
		repeat (40) send_pixel(rand_pixel());
		wait_idle();
	endtask

	// Receiver holds off for a long stretch while items keep coming back to back,
	// so the output stage fills and the input stalls
	task automatic test_output_backpressure();
		cfg_write(REG_WEIGHTS_LOW, rand_weight_reg());
		cfg_write(REG_BIAS,        rand_bias());
		cfg_write(REG_INPUT_WIDTH, 64'd6);
		tx_gap_on = 1'b0;
		hold_requests++;
		repeat (108) send_pixel(rand_pixel());
		tx_gap_on = 1'b1;
		wait_idle();
	endtask

	// Random phases: new settings between phases, full and partial frames,
	// widths below and above the legal span, quiet and idling stretches
	task automatic test_random_frames();
		int          r;
		int          wsel;
		int unsigned side;
		int          n;
		while (pixels_sent < ITEM_TARGET) begin
			tx_gap_on  = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 1)) cfg_write(REG_WEIGHTS_LOW,  rand_weight_reg());
			if ($urandom_range(0, 1)) cfg_write(REG_WEIGHTS_MID,  rand_weight_reg());
			if ($urandom_range(0, 1)) cfg_write(REG_WEIGHTS_HIGH, rand_weight_reg());
			if ($urandom_range(0, 3) == 0) cfg_write(REG_WEIGHTS_TOP, rand_weight_reg());
			if ($urandom_range(0, 1)) cfg_write(REG_BIAS, rand_bias());

			r = $urandom_range(0, 19);
			if (r < 14)      wsel = $urandom_range(4, 12);
			else if (r < 16) wsel = $urandom_range(0, 3);
			else if (r < 17) wsel = $urandom_range(257, 511);
			else             wsel = $urandom_range(13, 20);
			cfg_write(REG_INPUT_WIDTH, APB_DATA_W'(wsel));

			side = (wsel < MIN_WIDTH) ? MIN_WIDTH : ((wsel > MAXW) ? MAXW : wsel);
			if (side == MAXW)
				n = $urandom_range(260, 300);   // just past one saturated row
			else if ($urandom_range(0, 3) == 0)
				n = $urandom_range(1, side * side - 1);   // leave the frame open
			else
				n = side * side * $urandom_range(1, 2);
			// keep the total item count close to the target
			if (n > ITEM_TARGET + ITEM_SLACK - pixels_sent)
				n = ITEM_TARGET + ITEM_SLACK - pixels_sent;
			repeat (n) send_pixel(rand_pixel());
			wait_idle();
		end
		tx_gap_on  = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// Receiver: random stall runs, a long hold when requested, none when quiet
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			rx_left     = LONG_HOLD;
		end
		if (rx_left > 0) begin
			result_stall <= 1'b1;
			rx_left--;
		end else if (!rx_idle_on || $urandom_range(0, 99) < 70) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= 1'b1;
			rx_left = pick_gap();
		end
	end

	// Compare each accepted result with the oldest pending expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing pending: value=%0d last=%0b", value, last);
				err_count++;
			end else begin
				chk_want = expected_results.pop_front();
				if (value !== chk_want.value) begin
					$error("value: expected %0d, got %0d", chk_want.value, value);
					err_count++;
				end
				if (last !== chk_want.last) begin
					$error("last: expected %0b, got %0b", chk_want.last, last);
					err_count++;
				end
			end
		end
	end

	// Hard stop in case the handshake hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("conv2d_valid_single_kernel test failed");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_extremes();
		test_wide_image();
		test_output_backpressure();
		test_random_frames();
		wait_idle();

		if (err_count == 0 && expected_results.size() == 0) begin
			$display("conv2d_valid_single_kernel test passed");
		end else begin
			$display("conv2d_valid_single_kernel test failed");
		end
		$finish;
	end

endmodule

// File: files.f
src/c2dv_pkg.sv
src/c2dv_line_store.sv
src/c2dv_mac.sv
src/conv2d_valid_single_kernel.sv
verif/conv2d_valid_single_kernel_tb.sv
